// ===== src/crcsfb_pkg.sv =====
// shared types, constants and the crc-16 byte update for the frame builder
// no dependencies
package crcsfb_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned SlotCnt  = 9;
  localparam int unsigned CntW     = 4;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
  localparam logic [CrcW-1:0] CrcInit = 16'h0000;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'd2;
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'd3;
  localparam logic [ByteW-1:0] StopMarkerRst  = 8'd4;

  typedef enum logic [CfgAddrW-1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1,
    REG_STOP_MARKER  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             frame_end;
    logic [ByteW-1:0] line_byte;
  } slot_t;

  // xmodem crc, msb first, one byte
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < ByteW; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/crc16_stuffed_frame_builder.sv =====
// crc-16 byte-stuffed frame builder, top level
// depends on crcsfb_pkg
//
// channel  | direction | tdata              | tlast
// in_      | sink      | [7:0] payload_byte | payload_last
// out_     | source    | [7:0] line_byte    | frame_end
// cfg_     | sink      | [7:0] marker value | -
//
// a payload byte is expanded combinationally and loaded into a 9-slot shift buffer that drains
// one line byte per cycle while out_tready is high, so an item yields 1 to 9 line bytes
// a new item is taken in the same cycle the last buffered byte is taken
// sync active-low reset clears crc, frame flag and buffer count, reloads default markers
// output stalls only hold the buffer; crc and frame state advance on input
module crc16_stuffed_frame_builder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [crcsfb_pkg::ByteW-1:0]  in_tdata,   // [7:0] payload_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [crcsfb_pkg::ByteW-1:0]  out_tdata,  // [7:0] line_byte
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [crcsfb_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [crcsfb_pkg::ByteW-1:0]  cfg_wdata
);
  import crcsfb_pkg::*;

  logic [ByteW-1:0] start_r, end_r, stop_r;
  logic [CrcW-1:0]  crc_r, crc_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  slot_t            buf_r [SlotCnt];
  slot_t            buf_nxt [SlotCnt];
  slot_t            build [SlotCnt];
  logic [CntW-1:0]  build_n;
  logic [CrcW-1:0]  crc_new;
  logic             in_xfer, out_xfer;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[0].line_byte;
  assign out_tlast  = buf_r[0].frame_end;
  assign out_xfer   = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == '0) || ((cnt_r == CntW'(1)) && out_tready);
  assign in_xfer    = in_tvalid && in_tready;
  assign crc_new    = crc_byte(crc_r, in_tdata);

  // expand one payload byte into its line bytes
  always_comb begin
    logic [ByteW-1:0] b;
    for (int i = 0; i < SlotCnt; i++) begin
      build[i] = '0;
    end
    build_n = '0;
    if (!in_frame_r) begin
      build[build_n] = '{frame_end: 1'b0, line_byte: start_r};
      build_n = build_n + CntW'(1);
    end
    b = in_tdata;
    build[build_n] = '{frame_end: 1'b0, line_byte: b};
    build_n = build_n + CntW'(1);
    if (b == start_r || b == end_r) begin
      build[build_n] = '{frame_end: 1'b0, line_byte: b};
      build_n = build_n + CntW'(1);
    end
    if (in_tlast) begin
      b = crc_new[ByteW-1:0];
      build[build_n] = '{frame_end: 1'b0, line_byte: b};
      build_n = build_n + CntW'(1);
      if (b == start_r || b == end_r) begin
        build[build_n] = '{frame_end: 1'b0, line_byte: b};
        build_n = build_n + CntW'(1);
      end
      b = crc_new[CrcW-1:ByteW];
      build[build_n] = '{frame_end: 1'b0, line_byte: b};
      build_n = build_n + CntW'(1);
      if (b == start_r || b == end_r) begin
        build[build_n] = '{frame_end: 1'b0, line_byte: b};
        build_n = build_n + CntW'(1);
      end
      build[build_n] = '{frame_end: 1'b0, line_byte: end_r};
      build_n = build_n + CntW'(1);
      build[build_n] = '{frame_end: 1'b1, line_byte: stop_r};
      build_n = build_n + CntW'(1);
    end
  end

  always_comb begin
    crc_nxt      = crc_r;
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    for (int i = 0; i < SlotCnt - 1; i++) begin
      buf_nxt[i] = out_xfer ? buf_r[i+1] : buf_r[i];
    end
    buf_nxt[SlotCnt-1] = out_xfer ? '0 : buf_r[SlotCnt-1];
    if (out_xfer) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
    if (in_xfer) begin
      buf_nxt      = build;
      cnt_nxt      = build_n;
      crc_nxt      = in_tlast ? CrcInit : crc_new;
      in_frame_nxt = !in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CrcInit;
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      crc_r      <= crc_nxt;
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= StartMarkerRst;
      end_r   <= EndMarkerRst;
      stop_r  <= StopMarkerRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_MARKER: start_r <= cfg_wdata;
        REG_END_MARKER:   end_r   <= cfg_wdata;
        REG_STOP_MARKER:  stop_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(SlotCnt))
    else $error("buffer count out of range");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_tvalid)
    else $error("accepted item produced no line byte");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> (crc_r == CrcInit) && !in_frame_r)
    else $error("frame state not cleared after last byte");

  a_stop_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> cnt_r == CntW'(1))
    else $error("stop marker not at end of buffer");

  a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_frame_r |=> out_tdata == $past(start_r))
    else $error("frame did not open with start marker");

endmodule
